/* hw/rtl/tmgc_pkg.sv */
package tmgc_pkg;

	localparam int unsigned SAMPLES = 10;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned SUM_W = 22;
	localparam int unsigned CNT_W = $clog2(SAMPLES + 1);
	localparam int unsigned DIVD_W = 26;
	localparam int unsigned STEP_W = $clog2(DIVD_W);
	localparam int unsigned GAIN_SCALE = 1000;
	localparam int unsigned IDX_W = 3;

	localparam logic [SAMPLE_W-1:0] UNITY_GAIN = 16'd1000;
	localparam logic [SAMPLE_W-1:0] GAIN_SAT = 16'hffff;
	localparam logic [SAMPLE_W-1:0] MIN_RST = 16'hffff;
	localparam logic [SAMPLE_W-1:0] MEAN_DIV = SAMPLE_W'(SAMPLES - 2);

	localparam logic [SAMPLE_W-1:0] CELL_LOW_RST = 16'd405;
	localparam logic [SAMPLE_W-1:0] CELL_HIGH_RST = 16'd435;
	localparam logic [SAMPLE_W-1:0] PACK_LOW_RST = 16'd810;
	localparam logic [SAMPLE_W-1:0] PACK_HIGH_RST = 16'd870;
	localparam logic [SAMPLE_W-1:0] CELL_TARGET_RST = 16'd420;
	localparam logic [SAMPLE_W-1:0] PACK_TARGET_RST = 16'd840;

	typedef enum logic [IDX_W-1:0] {
		REG_CELL_LOW    = 3'd0,
		REG_CELL_HIGH   = 3'd1,
		REG_PACK_LOW    = 3'd2,
		REG_PACK_HIGH   = 3'd3,
		REG_CELL_TARGET = 3'd4,
		REG_PACK_TARGET = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MEAN,
		ST_LOAD,
		ST_RUN,
		ST_OUT
	} state_t;

	typedef enum logic {
		OP_CELL_GAIN,
		OP_PACK_GAIN
	} op_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [SAMPLE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic             last;
		logic [SUM_W-1:0] cell_trim;
		logic [SUM_W-1:0] pack_trim;
	} acc_stat_t;

endpackage

/* hw/rtl/tmgc_if.sv */
interface tmgc_sample_if;
	import tmgc_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] cell_sample;
	logic [SAMPLE_W-1:0] pack_sample;

	modport source (output valid, output cell_sample, output pack_sample, input ready);
	modport sink (input valid, input cell_sample, input pack_sample, output ready);
endinterface

interface tmgc_result_if;
	import tmgc_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] cell_mean;
	logic [SAMPLE_W-1:0] pack_mean;
	logic                in_window;
	logic [SAMPLE_W-1:0] cell_gain;
	logic [SAMPLE_W-1:0] pack_gain;

	modport source (output valid, output cell_mean, output pack_mean, output in_window,
		output cell_gain, output pack_gain, input ready);
	modport sink (input valid, input cell_mean, input pack_mean, input in_window,
		input cell_gain, input pack_gain, output ready);
endinterface

interface tmgc_cfg_if;
	import tmgc_pkg::*;

	logic                valid;
	logic                ready;
	logic [IDX_W-1:0]    index;
	logic [SAMPLE_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/tmgc_accum.sv */
module tmgc_accum (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            take,
	input  logic                            clear,
	input  logic [tmgc_pkg::SAMPLE_W-1:0]   cell_sample,
	input  logic [tmgc_pkg::SAMPLE_W-1:0]   pack_sample,
	output tmgc_pkg::acc_stat_t             stat
);
	import tmgc_pkg::*;

	logic [SUM_W-1:0]    cell_sum_q;
	logic [SUM_W-1:0]    pack_sum_q;
	logic [SAMPLE_W-1:0] cell_min_q;
	logic [SAMPLE_W-1:0] cell_max_q;
	logic [SAMPLE_W-1:0] pack_min_q;
	logic [SAMPLE_W-1:0] pack_max_q;
	logic [CNT_W-1:0]    count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_sum_q <= '0;
			pack_sum_q <= '0;
			cell_min_q <= MIN_RST;
			cell_max_q <= '0;
			pack_min_q <= MIN_RST;
			pack_max_q <= '0;
			count_q    <= '0;
		end else if (clear) begin
			cell_sum_q <= '0;
			pack_sum_q <= '0;
			cell_min_q <= MIN_RST;
			cell_max_q <= '0;
			pack_min_q <= MIN_RST;
			pack_max_q <= '0;
			count_q    <= '0;
		end else if (take) begin
			cell_sum_q <= cell_sum_q + SUM_W'(cell_sample);
			pack_sum_q <= pack_sum_q + SUM_W'(pack_sample);
			if (cell_sample < cell_min_q) cell_min_q <= cell_sample;
			if (cell_sample > cell_max_q) cell_max_q <= cell_sample;
			if (pack_sample < pack_min_q) pack_min_q <= pack_sample;
			if (pack_sample > pack_max_q) pack_max_q <= pack_sample;
			count_q <= count_q + CNT_W'(1);
		end
	end

	assign stat.last      = (count_q == CNT_W'(SAMPLES - 1));
	assign stat.cell_trim = cell_sum_q - SUM_W'(cell_min_q) - SUM_W'(cell_max_q);
	assign stat.pack_trim = pack_sum_q - SUM_W'(pack_min_q) - SUM_W'(pack_max_q);

endmodule

/* hw/rtl/tmgc_div.sv */
module tmgc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  tmgc_pkg::div_req_t req,
	output tmgc_pkg::div_rsp_t rsp
);
	import tmgc_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic [SAMPLE_W-1:0] rem_q;
	logic [SAMPLE_W-1:0] dvs_q;
	logic [DIVD_W-1:0]   quo_q;
	logic [SAMPLE_W:0]   shifted;
	logic [SAMPLE_W:0]   trial;
	logic                fits;

	assign shifted = {rem_q, quo_q[DIVD_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign fits    = (shifted >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[SAMPLE_W-1:0] : shifted[SAMPLE_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

/* hw/rtl/trimmed_mean_gain_calibrator_unit.sv */
// Channel   Role   Payload
// samples   sink   cell_sample, pack_sample
// results   source cell_mean, pack_mean, in_window, cell_gain, pack_gain
// cfg       sink   index, data (write only, always ready)
//
// Pairs that do not end a batch are accepted back to back. The pair that ends a
// batch is transferred, then the trimmed means are formed; when a mean falls
// outside its window no division follows, otherwise two divisions run through the
// one restoring divider (one quotient bit a cycle). Last the result register is
// loaded, and only then is a new pair accepted.
// The result register holds a result until it is taken; a finished batch waits
// for it to drain. Reset restores register defaults and clears the accumulators.
module trimmed_mean_gain_calibrator_unit (
	input  logic   clk,
	input  logic   arst_n,
	tmgc_sample_if.sink   samples,
	tmgc_result_if.source results,
	tmgc_cfg_if.sink      cfg
);
	import tmgc_pkg::*;

	state_t    state_q, state_d;
	op_t       op_q, op_d;
	div_req_t  div_req;
	div_rsp_t  div_rsp;
	acc_stat_t acc_stat;

	logic take;
	logic acc_clear;
	logic out_load;
	logic win_ok;

	logic [SAMPLE_W-1:0] cell_low_q, cell_high_q, pack_low_q, pack_high_q;
	logic [SAMPLE_W-1:0] cell_target_q, pack_target_q;
	logic [SAMPLE_W-1:0] cm_q, pm_q, cg_q, pg_q;
	logic                ok_q;
	logic [SAMPLE_W-1:0] mean_c;
	logic [SAMPLE_W-1:0] mean_p;
	logic [SAMPLE_W-1:0] quo_gain;
	logic [SAMPLE_W-1:0] target_sel;
	logic [DIVD_W-1:0]   product;

	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_cm_q, out_pm_q, out_cg_q, out_pg_q;
	logic                out_ok_q;

	assign take = samples.valid && samples.ready;
	assign cfg.ready = 1'b1;

	tmgc_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.clear       (acc_clear),
		.cell_sample (samples.cell_sample),
		.pack_sample (samples.pack_sample),
		.stat        (acc_stat)
	);

	tmgc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_low_q    <= CELL_LOW_RST;
			cell_high_q   <= CELL_HIGH_RST;
			pack_low_q    <= PACK_LOW_RST;
			pack_high_q   <= PACK_HIGH_RST;
			cell_target_q <= CELL_TARGET_RST;
			pack_target_q <= PACK_TARGET_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CELL_LOW:    cell_low_q    <= cfg.data;
				REG_CELL_HIGH:   cell_high_q   <= cfg.data;
				REG_PACK_LOW:    pack_low_q    <= cfg.data;
				REG_PACK_HIGH:   pack_high_q   <= cfg.data;
				REG_CELL_TARGET: cell_target_q <= cfg.data;
				REG_PACK_TARGET: pack_target_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign mean_c = SAMPLE_W'(acc_stat.cell_trim / SUM_W'(MEAN_DIV));
	assign mean_p = SAMPLE_W'(acc_stat.pack_trim / SUM_W'(MEAN_DIV));
	assign win_ok = (mean_c > cell_low_q) && (mean_c < cell_high_q)
		&& (mean_p > pack_low_q) && (mean_p < pack_high_q);

	assign quo_gain = (|div_rsp.quotient[DIVD_W-1:SAMPLE_W]) ? GAIN_SAT
		: div_rsp.quotient[SAMPLE_W-1:0];

	assign target_sel = (op_q == OP_CELL_GAIN) ? cell_target_q : pack_target_q;
	assign product = DIVD_W'(target_sel) * DIVD_W'(GAIN_SCALE);

	always_comb begin
		div_req.dividend = product;
		case (op_q)
			OP_CELL_GAIN: div_req.divisor = cm_q;
			default:      div_req.divisor = pm_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_CELL_GAIN;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		op_d            = op_q;
		samples.ready   = 1'b0;
		div_req.start   = 1'b0;
		acc_clear       = 1'b0;
		out_load        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				samples.ready = 1'b1;
				op_d = OP_CELL_GAIN;
				if (samples.valid && acc_stat.last) state_d = ST_MEAN;
			end
			ST_MEAN: begin
				state_d = win_ok ? ST_LOAD : ST_OUT;
			end
			ST_LOAD: begin
				div_req.start = 1'b1;
				state_d = ST_RUN;
			end
			ST_RUN: begin
				if (div_rsp.done) begin
					case (op_q)
						OP_CELL_GAIN: begin
							op_d = OP_PACK_GAIN;
							state_d = ST_LOAD;
						end
						default: state_d = ST_OUT;
					endcase
				end
			end
			ST_OUT: begin
				if (!out_valid_q || results.ready) begin
					out_load  = 1'b1;
					acc_clear = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MEAN) begin
			cm_q <= mean_c;
			pm_q <= mean_p;
			ok_q <= win_ok;
			cg_q <= UNITY_GAIN;
			pg_q <= UNITY_GAIN;
		end else if ((state_q == ST_RUN) && div_rsp.done) begin
			case (op_q)
				OP_CELL_GAIN: cg_q <= quo_gain;
				default:      pg_q <= quo_gain;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_cm_q <= cm_q;
			out_pm_q <= pm_q;
			out_ok_q <= ok_q;
			out_cg_q <= cg_q;
			out_pg_q <= pg_q;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.cell_mean = out_cm_q;
	assign results.pack_mean = out_pm_q;
	assign results.in_window = out_ok_q;
	assign results.cell_gain = out_cg_q;
	assign results.pack_gain = out_pg_q;

endmodule

/* tb/tmgc_result_check.sv */
module tmgc_result_check (
	input  logic        clk,
	input  logic        arst_n,
	tmgc_sample_if      samples,
	tmgc_result_if      results,
	tmgc_cfg_if         cfg,
	output int unsigned errors,
	output int unsigned pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import tmgc_pkg::*;

	typedef struct packed {
		logic [SAMPLE_W-1:0] cell_mean;
		logic [SAMPLE_W-1:0] pack_mean;
		logic                in_window;
		logic [SAMPLE_W-1:0] cell_gain;
		logic [SAMPLE_W-1:0] pack_gain;
	} calib_t;

	logic [SAMPLE_W-1:0] setting [0:REG_PACK_TARGET];
	logic [SUM_W-1:0]    cell_sum;
	logic [SUM_W-1:0]    pack_sum;
	logic [SAMPLE_W-1:0] cell_lo;
	logic [SAMPLE_W-1:0] cell_hi;
	logic [SAMPLE_W-1:0] pack_lo;
	logic [SAMPLE_W-1:0] pack_hi;
	int unsigned         pair_count;
	int unsigned         result_count;
	calib_t              due_results [$];

	function automatic logic [SAMPLE_W-1:0] trim_mean(logic [SUM_W-1:0] sum,
		logic [SAMPLE_W-1:0] lo, logic [SAMPLE_W-1:0] hi);
		logic [SUM_W-1:0] rest;
		rest = sum - SUM_W'(lo) - SUM_W'(hi);
		return SAMPLE_W'(rest / SUM_W'(SAMPLES - 2));
	endfunction

	function automatic logic [SAMPLE_W-1:0] gain_for(logic [SAMPLE_W-1:0] target,
		logic [SAMPLE_W-1:0] mean);
		logic [31:0] quot;
		if (mean == '0) begin
			return UNITY_GAIN;
		end
		quot = (32'(target) * GAIN_SCALE) / 32'(mean);
		return (quot > 32'(GAIN_SAT)) ? GAIN_SAT : quot[SAMPLE_W-1:0];
	endfunction

	task automatic start_batch();
		cell_sum = '0;
		pack_sum = '0;
		cell_lo = MIN_RST;
		pack_lo = MIN_RST;
		cell_hi = '0;
		pack_hi = '0;
		pair_count = 0;
	endtask

	task automatic note_mismatch(input string msg);
		errors++;
		if (errors <= 10) begin
			$display("%s", msg);
		end
	endtask

	task automatic absorb(input logic [SAMPLE_W-1:0] c, input logic [SAMPLE_W-1:0] p);
		calib_t r;
		cell_sum = cell_sum + SUM_W'(c);
		pack_sum = pack_sum + SUM_W'(p);
		if (c > cell_hi) cell_hi = c;
		if (c < cell_lo) cell_lo = c;
		if (p > pack_hi) pack_hi = p;
		if (p < pack_lo) pack_lo = p;
		pair_count++;
		if (pair_count == SAMPLES) begin
			r.cell_mean = trim_mean(cell_sum, cell_lo, cell_hi);
			r.pack_mean = trim_mean(pack_sum, pack_lo, pack_hi);
			r.in_window = r.cell_mean > setting[REG_CELL_LOW] && r.cell_mean < setting[REG_CELL_HIGH]
				&& r.pack_mean > setting[REG_PACK_LOW] && r.pack_mean < setting[REG_PACK_HIGH];
			r.cell_gain = r.in_window ? gain_for(setting[REG_CELL_TARGET], r.cell_mean) : UNITY_GAIN;
			r.pack_gain = r.in_window ? gain_for(setting[REG_PACK_TARGET], r.pack_mean) : UNITY_GAIN;
			due_results.push_back(r);
			start_batch();
		end
	endtask

	task automatic take_result();
		calib_t want;
		result_count++;
		if (due_results.size() == 0) begin
			note_mismatch($sformatf("result %0d: none expected, got mean %0d/%0d window %0b gain %0d/%0d",
				result_count, results.cell_mean, results.pack_mean, results.in_window,
				results.cell_gain, results.pack_gain));
		end else begin
			want = due_results.pop_front();
			if (results.cell_mean !== want.cell_mean || results.pack_mean !== want.pack_mean
				|| results.in_window !== want.in_window || results.cell_gain !== want.cell_gain
				|| results.pack_gain !== want.pack_gain) begin
				note_mismatch($sformatf({"result %0d: expected mean %0d/%0d window %0b gain %0d/%0d,",
					" got mean %0d/%0d window %0b gain %0d/%0d"},
					result_count, want.cell_mean, want.pack_mean, want.in_window,
					want.cell_gain, want.pack_gain, results.cell_mean, results.pack_mean,
					results.in_window, results.cell_gain, results.pack_gain));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setting[REG_CELL_LOW] = CELL_LOW_RST;
			setting[REG_CELL_HIGH] = CELL_HIGH_RST;
			setting[REG_PACK_LOW] = PACK_LOW_RST;
			setting[REG_PACK_HIGH] = PACK_HIGH_RST;
			setting[REG_CELL_TARGET] = CELL_TARGET_RST;
			setting[REG_PACK_TARGET] = PACK_TARGET_RST;
			start_batch();
			due_results.delete();
			result_count = 0;
			errors = 0;
			pending = 0;
		end else begin
			if (samples.valid && samples.ready) absorb(samples.cell_sample, samples.pack_sample);
			if (results.valid && results.ready) take_result();
			if (cfg.valid && cfg.ready && cfg.index <= REG_PACK_TARGET) setting[cfg.index] = cfg.data;
			pending = due_results.size();
		end
	end

endmodule

/* tb/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tmgc_pkg::*;

	localparam int FIELD_MAX = 65535;
	localparam int RANDOM_PAIRS = 500;
	localparam int SETTLE_CYCLES = 130;
	localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic        clk;
	logic        arst_n;
	int unsigned errors;
	int unsigned pending;
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned pairs_sent;

	logic [SAMPLE_W-1:0] cal_plan [0:REG_PACK_TARGET];
	int                  cell_center;
	int                  pack_center;
	int                  reach;
	bit                  noisy;

	tmgc_sample_if samples ();
	tmgc_result_if results ();
	tmgc_cfg_if    cfg ();

	trimmed_mean_gain_calibrator_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.results (results),
		.cfg     (cfg)
	);

	tmgc_result_check i_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.results (results),
		.cfg     (cfg),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		results.ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic logic [SAMPLE_W-1:0] rnd16();
		return SAMPLE_W'($urandom_range(FIELD_MAX, 0));
	endfunction

	function automatic int pick_center(logic [SAMPLE_W-1:0] lo, logic [SAMPLE_W-1:0] hi);
		case ($urandom_range(9))
			0: return int'(lo);
			1: return int'(hi);
			default: begin
				if (int'(hi) > int'(lo) + 1) return int'($urandom_range(int'(hi) - 1, int'(lo) + 1));
			end
		endcase
		return int'(rnd16());
	endfunction

	function automatic logic [SAMPLE_W-1:0] near(int center, int span);
		int v;
		if ($urandom_range(9) == 0) begin
			return rnd16();
		end
		v = center + int'($urandom_range(2 * span, 0)) - span;
		if (v < 0) begin
			v = 0;
		end else if (v > FIELD_MAX) begin
			v = FIELD_MAX;
		end
		return SAMPLE_W'(v);
	endfunction

	task automatic send_pair(input logic [SAMPLE_W-1:0] c, input logic [SAMPLE_W-1:0] p);
		while ($urandom_range(99) < idle_pct) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.cell_sample <= c;
		samples.pack_sample <= p;
		do @(posedge clk); while (!samples.ready);
		pairs_sent++;
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
	endtask

	task automatic program_regs(input logic [SAMPLE_W-1:0] cl, input logic [SAMPLE_W-1:0] ch,
		input logic [SAMPLE_W-1:0] pl, input logic [SAMPLE_W-1:0] ph,
		input logic [SAMPLE_W-1:0] ct, input logic [SAMPLE_W-1:0] pt);
		reg_idx_t r;
		cal_plan[REG_CELL_LOW] = cl;
		cal_plan[REG_CELL_HIGH] = ch;
		cal_plan[REG_PACK_LOW] = pl;
		cal_plan[REG_PACK_HIGH] = ph;
		cal_plan[REG_CELL_TARGET] = ct;
		cal_plan[REG_PACK_TARGET] = pt;
		r = r.first();
		do begin
			write_reg(r, cal_plan[r]);
			r = r.next();
		end while (r != r.first());
		write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, rnd16());
		cfg.valid <= 1'b0;
	endtask

	task automatic settle();
		samples.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		#2_000_000;
		$display("trimmed_mean_gain_calibrator_unit: mismatch");
		$finish;
	end

	initial begin
		int unsigned phase;
		int unsigned random_sent;
		int unsigned n;
		logic [SAMPLE_W-1:0] lo_a;
		logic [SAMPLE_W-1:0] lo_b;

		arst_n = 1'b0;
		samples.valid = 1'b0;
		samples.cell_sample = '0;
		samples.pack_sample = '0;
		results.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_CELL_LOW;
		cfg.data = '0;
		idle_pct = 0;
		stall_pct = 0;
		pairs_sent = 0;
		cal_plan[REG_CELL_LOW] = CELL_LOW_RST;
		cal_plan[REG_CELL_HIGH] = CELL_HIGH_RST;
		cal_plan[REG_PACK_LOW] = PACK_LOW_RST;
		cal_plan[REG_PACK_HIGH] = PACK_HIGH_RST;
		cal_plan[REG_CELL_TARGET] = CELL_TARGET_RST;
		cal_plan[REG_PACK_TARGET] = PACK_TARGET_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// in window at reset settings, extremes trimmed away
		for (int k = 0; k < SAMPLES; k++) begin
			send_pair(k == 0 ? '0 : (k == SAMPLES - 1 ? '1 : CELL_TARGET_RST),
				k == 0 ? '1 : (k == SAMPLES - 1 ? '0 : PACK_TARGET_RST));
		end
		// out of window: means still reported, pack mean zero
		for (int k = 0; k < SAMPLES; k++) begin
			send_pair('1, '0);
		end
		// registers change in the middle of a batch; gains saturate
		for (int k = 0; k < SAMPLES / 2; k++) begin
			send_pair(k == 0 ? '0 : SAMPLE_W'(1), SAMPLE_W'(3));
		end
		settle();
		program_regs('0, '1, '0, '1, '1, '1);
		for (int k = 0; k < SAMPLES / 2; k++) begin
			send_pair(k == SAMPLES / 2 - 1 ? SAMPLE_W'(2) : SAMPLE_W'(1), SAMPLE_W'(3));
		end

		phase = 0;
		random_sent = 0;
		while (random_sent < RANDOM_PAIRS) begin
			settle();
			case (phase % 8)
				0: program_regs(CELL_LOW_RST, CELL_HIGH_RST, PACK_LOW_RST, PACK_HIGH_RST,
					CELL_TARGET_RST, PACK_TARGET_RST);
				1: program_regs('0, '1, '0, '1, '1, '1);
				2: program_regs('0, '1, '0, '1, '0, '0);
				3: begin
					lo_a = rnd16();
					lo_b = rnd16();
					program_regs(lo_a, lo_a, lo_b, lo_b, rnd16(), rnd16());
				end
				4: begin
					lo_a = rnd16() | 16'h0001;
					lo_b = rnd16() | 16'h0001;
					program_regs(lo_a, lo_a >> 1, lo_b, lo_b >> 1, rnd16(), rnd16());
				end
				5: begin
					lo_a = rnd16() >> 1;
					lo_b = rnd16() >> 1;
					program_regs(lo_a, lo_a + SAMPLE_W'($urandom_range(4000, 2)),
						lo_b, lo_b + SAMPLE_W'($urandom_range(4000, 2)), rnd16(), rnd16());
				end
				6: begin
					lo_a = rnd16() >> 1;
					lo_b = rnd16() >> 1;
					program_regs(lo_a, lo_a + SAMPLE_W'(2), lo_b, lo_b + SAMPLE_W'(2),
						rnd16(), rnd16());
				end
				default: begin
					lo_a = rnd16() >> 8;
					lo_b = rnd16() >> 8;
					program_regs(lo_a, lo_a + SAMPLE_W'(40), lo_b, lo_b + SAMPLE_W'(40),
						rnd16(), rnd16());
				end
			endcase
			case (phase % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 82;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 82;
				end
				default: begin
					idle_pct = 35;
					stall_pct = 35;
				end
			endcase
			n = $urandom_range(75, 55);
			repeat (n) begin
				if (pairs_sent % SAMPLES == 0) begin
					noisy = ($urandom_range(4) == 0);
					cell_center = pick_center(cal_plan[REG_CELL_LOW], cal_plan[REG_CELL_HIGH]);
					pack_center = pick_center(cal_plan[REG_PACK_LOW], cal_plan[REG_PACK_HIGH]);
					case ($urandom_range(3))
						0: reach = 0;
						1: reach = 2;
						2: reach = 20;
						default: reach = 300;
					endcase
				end
				if (noisy) begin
					send_pair(rnd16(), rnd16());
				end else begin
					send_pair(near(cell_center, reach), near(pack_center, reach));
				end
				random_sent++;
			end
			phase++;
		end

		settle();
		if (errors == 0 && pending == 0) begin
			$display("trimmed_mean_gain_calibrator_unit: match");
		end else begin
			$display("trimmed_mean_gain_calibrator_unit: mismatch");
		end
		$finish;
	end

endmodule

/* files.f */
hw/rtl/tmgc_pkg.sv
hw/rtl/tmgc_if.sv
hw/rtl/tmgc_accum.sv
hw/rtl/tmgc_div.sv
hw/rtl/trimmed_mean_gain_calibrator_unit.sv
tb/tmgc_result_check.sv
tb/tb.sv
